FILE: rtl/rse_pkg.sv
package rse_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned SYM_W    = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;

    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNDERFLOW = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_DIGIT,
        KIND_ADD,
        KIND_SUB,
        KIND_MUL
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t kind;
        logic      is_op;
    } alu_ctl_t;

    function automatic sym_kind_t sym_kind(input logic [SYM_W-1:0] sym);
        sym_kind_t k;
        k = KIND_NONE;
        if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
            k = KIND_DIGIT;
        end else if (sym == CHAR_PLUS) begin
            k = KIND_ADD;
        end else if (sym == CHAR_MINUS) begin
            k = KIND_SUB;
        end else if (sym == CHAR_STAR) begin
            k = KIND_MUL;
        end
        return k;
    endfunction

endpackage

FILE: rtl/rse_ram.sv
module rse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rse_alu.sv
module rse_alu
    import rse_pkg::*;
(
    input  alu_ctl_t ctl,
    input  data_t    a,
    input  data_t    b,
    output data_t    result
);

    always_comb begin
        case (ctl.kind)
            KIND_ADD: result = a + b;
            KIND_SUB: result = a - b;
            KIND_MUL: result = a * b;
            default:  result = b;
        endcase
    end

endmodule

FILE: rtl/rpn_stack_evaluator.sv
// Output: a tlast word's result shows on m_tdata in the cycle after it is accepted.
// Throughput: one word per cycle unless a result stalls on m_tready; the top two entries
// are registers; the registered RAM read keeps the third ready for the next operator.
// Reset: synchronous, active-low aresetn empties the stack and clears the error status;
// stack memory contents are not cleared and need no clearing pass.
module rpn_stack_evaluator
    import rse_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);

    logic [CW-1:0] count_reg, count_next, count_proc;
    status_t       err_reg, err_next, err_proc;
    data_t         top_reg, top_next;
    data_t         sec_reg, sec_next;
    logic          m_valid_reg, m_valid_next;
    data_t         m_data_reg, m_data_next;
    status_t       m_status_reg, m_status_next;

    logic          accept;
    sym_kind_t     kind;
    alu_ctl_t      alu_ctl;
    data_t         alu_result;
    data_t         third;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    data_t         ram_wdata;
    data_t         digit;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = sym_kind(s_tdata);
    assign digit    = DATA_W'(s_tdata - CHAR_ZERO);

    assign alu_ctl.kind  = kind;
    assign alu_ctl.is_op = (kind == KIND_ADD) || (kind == KIND_SUB) || (kind == KIND_MUL);

    rse_alu u_alu (
        .ctl    (alu_ctl),
        .a      (sec_reg),
        .b      (top_reg),
        .result (alu_result)
    );

    rse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (third)
    );

    always_comb begin
        count_proc = count_reg;
        err_proc   = err_reg;
        top_next   = top_reg;
        sec_next   = sec_reg;
        ram_we     = 1'b0;
        ram_waddr  = AW'(count_reg);
        ram_wdata  = digit;
        if (accept) begin
            if (kind == KIND_DIGIT) begin
                if (count_reg < CW'(STACK_DEPTH)) begin
                    count_proc = count_reg + CW'(1);
                    top_next   = digit;
                    sec_next   = top_reg;
                    ram_we     = 1'b1;
                end else if (err_reg == ST_OK) begin
                    err_proc = ST_OVERFLOW;
                end
            end else if (alu_ctl.is_op) begin
                if (count_reg >= CW'(2)) begin
                    count_proc = count_reg - CW'(1);
                    top_next   = alu_result;
                    sec_next   = third;
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(count_reg - CW'(2));
                    ram_wdata  = alu_result;
                end else if (err_reg == ST_OK) begin
                    err_proc = ST_UNDERFLOW;
                end
            end
        end
        count_next = count_proc;
        err_next   = err_proc;
        if (accept && s_tlast) begin
            count_next = '0;
            err_next   = ST_OK;
        end
        ram_raddr = AW'(count_next - CW'(3));
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (accept && s_tlast) begin
            m_valid_next  = 1'b1;
            m_data_next   = (count_proc != '0) ? top_next : '0;
            m_status_next = err_proc;
            if (err_proc == ST_OK && count_proc == '0) begin
                m_status_next = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg      <= top_next;
        sec_reg      <= sec_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> count_reg == '0 && err_reg == ST_OK)
        else $error("stack not cleared after last word");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_EMPTY |-> m_tdata == '0)
        else $error("empty result carries nonzero value");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(accept && s_tlast))
        else $error("result without a last word");

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rse_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned WORK_ITEMS  = 550;

    typedef struct packed {
        data_t   value;
        status_t status;
    } rpn_result_t;

    class rpn_result_board;
        data_t       operands[STACK_DEPTH];
        int unsigned depth;
        status_t     first_error;
        rpn_result_t pending[$];
        int unsigned failures;

        function new();
            depth       = 0;
            first_error = ST_OK;
            failures    = 0;
        endfunction

        function void take_symbol(logic [SYM_W-1:0] sym, logic last);
            data_t       a;
            data_t       b;
            rpn_result_t res;
            if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
                if (depth >= STACK_DEPTH) begin
                    if (first_error == ST_OK) first_error = ST_OVERFLOW;
                end else begin
                    operands[depth] = data_t'(sym - CHAR_ZERO);
                    depth++;
                end
            end else if (sym == CHAR_PLUS || sym == CHAR_MINUS || sym == CHAR_STAR) begin
                if (depth < 2) begin
                    if (first_error == ST_OK) first_error = ST_UNDERFLOW;
                end else begin
                    b = operands[depth-1];
                    a = operands[depth-2];
                    case (sym)
                        CHAR_PLUS:  operands[depth-2] = a + b;
                        CHAR_MINUS: operands[depth-2] = a - b;
                        default:    operands[depth-2] = a * b;
                    endcase
                    depth--;
                end
            end
            if (last) begin
                if (depth > 0) begin
                    res.value  = operands[depth-1];
                    res.status = first_error;
                end else begin
                    res.value  = '0;
                    res.status = (first_error != ST_OK) ? first_error : ST_EMPTY;
                end
                pending.push_back(res);
                depth       = 0;
                first_error = ST_OK;
            end
        endfunction

        function void check_result(data_t value, status_t status);
            rpn_result_t want;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: value %0d status %0d", $signed(value), status);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value) begin
                failures++;
                if (failures <= 10)
                    $display("value mismatch: expected %0d got %0d",
                             $signed(want.value), $signed(value));
            end
            if (status !== want.status) begin
                failures++;
                if (failures <= 10)
                    $display("status mismatch: expected %0d got %0d", want.status, status);
            end
        endfunction
    endclass

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [SYM_W-1:0]  s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic [1:0]        m_tuser;

    rpn_result_board   sb = new();
    logic [SYM_W-1:0]  expr_q[$];
    logic [SYM_W-1:0]  op_chars[3] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR};
    bit                tx_gap   = 1'b1;
    bit                rx_stall = 1'b1;
    bit                hold_req = 1'b0;
    int unsigned       work_count = 0;

    rpn_stack_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit is_work(logic [SYM_W-1:0] ch);
        return (ch >= CHAR_ZERO && ch <= CHAR_NINE) ||
               ch == CHAR_PLUS || ch == CHAR_MINUS || ch == CHAR_STAR;
    endfunction

    task automatic send_word(logic [SYM_W-1:0] sym, logic last);
        int unsigned gap;
        gap = tx_gap ? $urandom_range(7, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.take_symbol(sym, last);
        work_count++;
        @(negedge aclk);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_q.size(); i++) begin
            send_word(expr_q[i], i == expr_q.size() - 1);
        end
    endtask

    task automatic send_text(string txt);
        expr_q.delete();
        for (int i = 0; i < txt.len(); i++) expr_q.push_back(txt[i]);
        send_expr();
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = rx_stall ? $urandom_range(7, 0) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        int unsigned      expr_n;
        int unsigned      sel;
        int unsigned      pushes;
        int unsigned      live;
        int unsigned      len;
        int unsigned      pick;
        bit               mul_bias;
        logic [SYM_W-1:0] ch;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        send_text("9");
        expr_q = '{"3", 8'h00, "8", CHAR_MINUS};
        send_expr();
        send_text("27*");
        send_text("+");
        expr_q = '{8'hFF};
        send_expr();
        send_text("5+");
        send_text("99999999999999999+");

        expr_n = 0;
        while (work_count < WORK_ITEMS) begin
            if (expr_n % 40 == 0) begin
                tx_gap   = 1'($urandom_range(1, 0));
                rx_stall = 1'($urandom_range(1, 0));
            end
            if (expr_n == 20) begin
                tx_gap   = 1'b0;
                hold_req = 1'b1;
            end
            expr_q.delete();
            sel = $urandom_range(9, 0);
            if (sel < 7) begin
                pushes   = ($urandom_range(7, 0) == 0) ? $urandom_range(24, 8)
                                                       : $urandom_range(6, 1);
                mul_bias = ($urandom_range(3, 0) == 0);
                live     = 0;
                while (pushes > 0 || live > 1) begin
                    if ($urandom_range(9, 0) == 0) begin
                        ch = SYM_W'($urandom_range(255, 0));
                        expr_q.push_back(is_work(ch) ? 8'h20 : ch);
                    end
                    if (pushes > 0 &&
                        (live < 2 || (live < STACK_DEPTH && $urandom_range(1, 0) == 1))) begin
                        ch = CHAR_ZERO + SYM_W'(mul_bias ? $urandom_range(9, 5)
                                                         : $urandom_range(9, 0));
                        expr_q.push_back(ch);
                        pushes--;
                        live++;
                    end else begin
                        if (mul_bias && $urandom_range(3, 0) != 0)
                            expr_q.push_back(CHAR_STAR);
                        else
                            expr_q.push_back(op_chars[$urandom_range(2, 0)]);
                        live--;
                    end
                end
            end else if (sel < 9) begin
                len = $urandom_range(24, 1);
                repeat (len) begin
                    pick = $urandom_range(9, 0);
                    if (pick < 5)
                        expr_q.push_back(CHAR_ZERO + SYM_W'($urandom_range(9, 0)));
                    else if (pick < 9)
                        expr_q.push_back(op_chars[$urandom_range(2, 0)]);
                    else
                        expr_q.push_back(SYM_W'($urandom_range(255, 0)));
                end
            end else begin
                len = $urandom_range(4, 1);
                repeat (len) expr_q.push_back(SYM_W'($urandom_range(255, 0)));
            end
            send_expr();
            expr_n++;
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
